FILE: src/ffca_pkg.sv
// shared types and constants of the first-fit capacity allocator
package ffca_pkg;

  localparam int CMD_W      = 1;
  localparam int INDEX_W    = 10;
  localparam int AMOUNT_W   = 32;
  localparam int SLOT_NUM_W = 11;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LEFT,
    RD_WALK_NEXT,
    RD_SIBLING,
    RD_PARENT_SIBLING
  } rd_sel_t;

  typedef struct packed {
    logic    clr;
    logic    start;
    logic    take_root;
    logic    set_miss;
    logic    walk;
    logic    leaf_wr;
    logic    up;
    logic    emit;
    rd_sel_t rd_sel;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic in_is_request;
    logic in_slot_ok;
    logic root_fits;
    logic node_is_leaf;
    logic next_is_leaf;
    logic node_is_root;
    logic parent_is_root;
    logic is_request;
  } stat_t;

endpackage

FILE: src/ffca_if.sv
// request and result channel interfaces of the allocator
interface ffca_req_if import ffca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [INDEX_W-1:0]    slot_index;
  logic [AMOUNT_W-1:0]   amount;

  modport source (output valid, command, slot_index, amount, input ready);
  modport sink   (input valid, command, slot_index, amount, output ready);
endinterface

interface ffca_res_if import ffca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_NUM_W-1:0] slot_number;

  modport source (output valid, slot_number, input ready);
  modport sink   (input valid, slot_number, output ready);
endinterface

FILE: src/ffca_ram.sv
// generic single-write, single-read ram with registered read data
module ffca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/ffca_datapath.sv
// max tree memory, walk and refresh datapath of the allocator
module ffca_datapath import ffca_pkg::*; #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctl,
  output stat_t                 stat,
  input  logic [CMD_W-1:0]      command,
  input  logic [INDEX_W-1:0]    slot_index,
  input  logic [AMOUNT_W-1:0]   amount,
  output logic [SLOT_NUM_W-1:0] slot_number
);

  localparam int LEVELS = $clog2(SLOTS);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODE_W = LEVELS + 1;
  localparam int DEPTH  = 2 * LEAVES;

  logic [NODE_W-1:0]      node;
  logic [NODE_W-1:0]      clr_cnt;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH-1:0] amt;
  logic                   is_req;
  logic [SLOT_NUM_W-1:0]  res;

  logic [VALUE_WIDTH-1:0] amt_in;
  logic [NODE_W-1:0]      leaf_in;
  logic                   fits;
  logic [NODE_W-1:0]      next_node;
  logic [NODE_W-1:0]      parent;
  logic [VALUE_WIDTH-1:0] leaf_val;
  logic [VALUE_WIDTH-1:0] up_val;
  logic [NODE_W-1:0]      leaf_off;
  logic [SLOT_NUM_W-1:0]  slot_calc;

  logic                   wr_en;
  logic [NODE_W-1:0]      wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [NODE_W-1:0]      rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  assign amt_in    = VALUE_WIDTH'(amount);
  assign leaf_in   = NODE_W'(LEAVES + 32'(slot_index));
  assign fits      = rd_data >= amt;
  assign next_node = (node << 1) | NODE_W'(!fits);
  assign parent    = node >> 1;
  assign leaf_val  = is_req ? cur - amt : cur;
  assign up_val    = (cur > rd_data) ? cur : rd_data;
  assign leaf_off  = node ^ NODE_W'(LEAVES);
  assign slot_calc = SLOT_NUM_W'(32'(leaf_off) + 32'd1);

  always_comb begin
    stat                = '0;
    stat.clear_last     = &clr_cnt;
    stat.in_is_request  = command == CMD_REQUEST;
    stat.in_slot_ok     = 32'(slot_index) < SLOTS;
    stat.root_fits      = fits;
    stat.node_is_leaf   = node[LEVELS];
    stat.next_is_leaf   = next_node[LEVELS];
    stat.node_is_root   = node == NODE_W'(1);
    stat.parent_is_root = parent == NODE_W'(1);
    stat.is_request     = is_req;
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_ROOT:           rd_addr = NODE_W'(1);
      RD_LEFT:           rd_addr = node << 1;
      RD_WALK_NEXT:      rd_addr = next_node << 1;
      RD_SIBLING:        rd_addr = node ^ NODE_W'(1);
      RD_PARENT_SIBLING: rd_addr = parent ^ NODE_W'(1);
      default:           rd_addr = NODE_W'(1);
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = leaf_val;
    if (ctl.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (ctl.leaf_wr) begin
      wr_en   = 1'b1;
    end else if (ctl.up) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = up_val;
    end
  end

  ffca_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr) begin
      clr_cnt <= clr_cnt + NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      node   <= (command == CMD_REQUEST) ? NODE_W'(1) : leaf_in;
      cur    <= amt_in;
      amt    <= amt_in;
      is_req <= command == CMD_REQUEST;
    end
    if (ctl.take_root) begin
      cur <= rd_data;
    end
    if (ctl.set_miss) begin
      res <= '0;
    end
    if (ctl.walk) begin
      node <= next_node;
      if (fits) begin
        cur <= rd_data;
      end
    end
    if (ctl.leaf_wr) begin
      cur <= leaf_val;
      res <= slot_calc;
    end
    if (ctl.up) begin
      cur  <= up_val;
      node <= parent;
    end
    if (ctl.emit) begin
      slot_number <= res;
    end
  end

endmodule

FILE: src/ffca_ctrl.sv
// sequencing state machine of the allocator
module ffca_ctrl import ffca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctl
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    CHECK,
    WALK,
    LEAF,
    UP,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = state == IDLE;

  always_comb begin
    ctl            = '0;
    ctl.rd_sel     = RD_ROOT;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      CLEAR: begin
        ctl.clr = 1'b1;
        if (stat.clear_last) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          if (stat.in_is_request) begin
            state_next = CHECK;
          end else if (stat.in_slot_ok) begin
            state_next = LEAF;
          end
        end
      end
      CHECK: begin
        ctl.rd_sel = RD_LEFT;
        if (!stat.root_fits) begin
          ctl.set_miss = 1'b1;
          state_next   = EMIT;
        end else begin
          ctl.take_root = 1'b1;
          state_next    = stat.node_is_leaf ? LEAF : WALK;
        end
      end
      WALK: begin
        ctl.walk   = 1'b1;
        ctl.rd_sel = RD_WALK_NEXT;
        if (stat.next_is_leaf) begin
          state_next = LEAF;
        end
      end
      LEAF: begin
        ctl.leaf_wr = 1'b1;
        ctl.rd_sel  = RD_SIBLING;
        if (stat.node_is_root) begin
          state_next = stat.is_request ? EMIT : IDLE;
        end else begin
          state_next = UP;
        end
      end
      UP: begin
        ctl.up     = 1'b1;
        ctl.rd_sel = RD_PARENT_SIBLING;
        if (stat.parent_is_root) begin
          state_next = stat.is_request ? EMIT : IDLE;
        end
      end
      EMIT: begin
        if (!out_valid || out_ready) begin
          ctl.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: src/first_fit_capacity_allocator.sv
// first-fit capacity allocator: top level
// Keeps a max tree over the remaining capacity of SLOTS slots in one ram with a single
// read port, visited one tree level per cycle; L = clog2(SLOTS) levels (10 by default).
// After reset the tree is cleared one entry a cycle, all 2 * next_pow2(SLOTS) entries (2048
// by default), before the first item is taken. A load writes its leaf and refreshes the
// levels above it before the next item is taken; a load beyond the last slot changes nothing.
// A request that fits walks down L levels, updates the leaf and refreshes L levels
// upward before its result; one that does not fit answers slot 0. A result waits in
// its own register, so the next item is taken while it is still unread.
module first_fit_capacity_allocator import ffca_pkg::*; #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  ffca_req_if.sink   request,
  ffca_res_if.source result
);

  ctrl_t ctl;
  stat_t stat;

  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ffca_datapath #(
    .SLOTS       (SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (request.command),
    .slot_index  (request.slot_index),
    .amount      (request.amount),
    .slot_number (result.slot_number)
  );

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (32'(result.slot_number) <= SLOTS))
    else $error("slot number beyond slot count");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.clr, ctl.start, ctl.take_root, ctl.walk, ctl.leaf_wr, ctl.up}))
    else $error("more than one datapath operation at once");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready && request.command == CMD_REQUEST) |=> !request.ready)
    else $error("new item taken while a request is in progress");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.walk |-> !request.ready && !ctl.emit)
    else $error("walk overlaps intake or result");

endmodule

FILE: tb/allocation_checker.sv
// checker that predicts the allocator's slot numbers and compares them with its results
module allocation_checker import ffca_pkg::*; #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  ffca_req_if  req,
  ffca_res_if  res,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1 << $clog2(SLOTS);

  logic [VALUE_WIDTH-1:0] cap_tree [2*LEAVES];
  logic [SLOT_NUM_W-1:0]  expected_slots [$];
  logic [SLOT_NUM_W-1:0]  want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void refresh_above(input int node);
    int n;
    n = node >> 1;
    while (n > 0) begin
      cap_tree[n] = (cap_tree[2*n] > cap_tree[2*n+1]) ? cap_tree[2*n] : cap_tree[2*n+1];
      n = n >> 1;
    end
  endfunction

  function automatic void apply_load(input logic [INDEX_W-1:0] idx,
                                     input logic [VALUE_WIDTH-1:0] cap);
    if (int'(idx) < SLOTS) begin
      cap_tree[LEAVES + int'(idx)] = cap;
      refresh_above(LEAVES + int'(idx));
    end
  endfunction

  function automatic logic [SLOT_NUM_W-1:0] allocate(input logic [VALUE_WIDTH-1:0] demand);
    int node;
    node = 1;
    if (cap_tree[1] < demand) return '0;
    while (node < LEAVES) begin
      if (cap_tree[2*node] >= demand) node = 2 * node;
      else node = 2 * node + 1;
    end
    cap_tree[node] = cap_tree[node] - demand;
    refresh_above(node);
    return SLOT_NUM_W'(node - LEAVES + 1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2*LEAVES; i++) cap_tree[i] = '0;
      expected_slots.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_slots.size() == 0) begin
          report_mismatch($sformatf("slot %0d with no request waiting", res.slot_number));
        end else begin
          want = expected_slots.pop_front();
          if (res.slot_number !== want)
            report_mismatch($sformatf("slot %0d, expected %0d", res.slot_number, want));
        end
      end
      if (req.valid && req.ready) begin
        if (req.command == CMD_LOAD) begin
          apply_load(req.slot_index, VALUE_WIDTH'(req.amount));
        end else begin
          expected_slots.push_back(allocate(VALUE_WIDTH'(req.amount)));
        end
      end
    end
    pending = expected_slots.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top of the first-fit capacity allocator: stimulus, flow control and verdict
module tb import ffca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1880;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   results_taken;

  ffca_req_if request_ch ();
  ffca_res_if result_ch ();

  first_fit_capacity_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  allocation_checker allocation_check (
    .clk        (clk),
    .rst        (rst),
    .req        (request_ch),
    .res        (result_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      results_taken <= 0;
    end else if (result_ch.valid && result_ch.ready) begin
      results_taken <= results_taken + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                               input logic [AMOUNT_W-1:0] amt, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid      <= 1'b1;
    request_ch.command    <= cmd;
    request_ch.slot_index <= idx;
    request_ch.amount     <= amt;
    @(negedge clk);
    while (!request_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // result side: random stalls, runs with ready held high, and one long hold-off
  initial begin
    bit held_off;
    int gap;
    held_off = 1'b0;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!held_off && results_taken >= 400) begin
        held_off = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = ($urandom_range(0, 9) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  initial begin
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;
    int                  r;
    int                  wait_cycles;
    bit                  quiet;

    rst                   <= 1'b1;
    request_ch.valid      <= 1'b0;
    request_ch.command    <= CMD_LOAD;
    request_ch.slot_index <= '0;
    request_ch.amount     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty tree: zero demand still gets slot 1, any other demand misses
    offer_request(CMD_REQUEST, 10'h3FF, 32'd0, 1'b0);
    offer_request(CMD_REQUEST, 10'h000, 32'd1, 1'b0);
    // extremes of slot and amount
    offer_request(CMD_LOAD, 10'h3FF, 32'hFFFF_FFFF, 1'b0);
    offer_request(CMD_LOAD, 10'h000, 32'd0, 1'b0);
    offer_request(CMD_REQUEST, 10'h155, 32'hFFFF_FFFF, 1'b0);
    offer_request(CMD_REQUEST, 10'h2AA, 32'd1, 1'b0);
    // first fit across both halves of the tree
    offer_request(CMD_LOAD, 10'd512, 32'd100, 1'b1);
    offer_request(CMD_LOAD, 10'd511, 32'd100, 1'b1);
    offer_request(CMD_LOAD, 10'd0, 32'd10, 1'b1);
    offer_request(CMD_REQUEST, 10'd0, 32'd10, 1'b0);
    offer_request(CMD_REQUEST, 10'd0, 32'd10, 1'b0);
    offer_request(CMD_REQUEST, 10'd0, 32'd100, 1'b0);
    offer_request(CMD_REQUEST, 10'd0, 32'd100, 1'b0);
    offer_request(CMD_REQUEST, 10'd0, 32'd0, 1'b0);
    // alternating bit patterns, exact fits
    offer_request(CMD_LOAD, 10'h3FF, 32'h8000_0000, 1'b0);
    offer_request(CMD_LOAD, 10'h155, 32'h5555_5555, 1'b0);
    offer_request(CMD_LOAD, 10'h2AA, 32'hAAAA_AAAA, 1'b0);
    offer_request(CMD_REQUEST, 10'h2AA, 32'h5555_5555, 1'b0);
    offer_request(CMD_REQUEST, 10'h155, 32'hAAAA_AAAA, 1'b0);
    offer_request(CMD_REQUEST, 10'h000, 32'h8000_0000, 1'b0);
    offer_request(CMD_REQUEST, 10'h3FF, 32'h0000_0001, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 900 && n < 1100);
      idx = INDEX_W'($urandom);
      if ($urandom_range(0, 99) < 30) begin
        cmd = CMD_LOAD;
        if ($urandom_range(0, 1) == 0) idx = INDEX_W'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 60) amt = $urandom_range(0, 2000);
        else if (r < 85) amt = $urandom;
        else amt = '0;
      end else begin
        cmd = CMD_REQUEST;
        r = $urandom_range(0, 99);
        if (r < 60) amt = $urandom_range(1, 2000);
        else if (r < 75) amt = '0;
        else if (r < 90) amt = $urandom;
        else amt = $urandom_range(2000, 100000);
      end
      offer_request(cmd, idx, amt, quiet);
    end
    request_ch.valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    wait_cycles = 40;
    repeat (wait_cycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
